// ===== rtl/twh_pkg.sv =====
// Package with constants, codes and types of the task worker hash table.
`default_nettype none
package twh_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int SLOTS       = 8;
    localparam int MAX_PROBES  = 3;
    localparam int LIST_MAX    = 8;
    localparam int Q_DEPTH     = 2;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ADDR_W = IDX_W + SLOT_W;
    localparam int PRB_W  = $clog2(MAX_PROBES + 1);
    localparam int N_W    = $clog2(LIST_MAX + 1);
    localparam int K_W    = $clog2(LIST_MAX);
    localparam int QP_W   = $clog2(Q_DEPTH);
    localparam int QC_W   = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_END    = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_ABSENT    = 2'd3;

    localparam logic [1:0] TAG_UNTOUCHED = 2'd0;
    localparam logic [1:0] TAG_EMPTY     = 2'd1;
    localparam logic [1:0] TAG_OCCUPIED  = 2'd2;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [31:0]      task_key;
        logic [7:0]       worker_id;
        logic [3:0]       max_count;
        logic [IDX_W-1:0] home;
    } t_job;

    typedef struct packed {
        logic [QC_W-1:0] count;
        logic            full;
    } t_q_stat;
endpackage
`default_nettype wire

// ===== rtl/twh_req_if.sv =====
// Request channel interface carrying one table operation.
`default_nettype none
interface twh_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] task_key;
    logic [7:0]  worker_id;
    logic [3:0]  max_count;
    modport source (output valid, opcode, task_key, worker_id, max_count, input ready);
    modport sink (input valid, opcode, task_key, worker_id, max_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/twh_res_if.sv =====
// Result channel interface carrying one result item.
`default_nettype none
interface twh_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       has_worker;
    logic [7:0] worker_out;
    logic       last;
    modport source (output valid, status, has_worker, worker_out, last, input ready);
    modport sink (input valid, status, has_worker, worker_out, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/task_worker_hash_table_core.sv =====
// Top level of the task worker hash table: front end, job queue and table engine.
//
// Requests arrive on i_req (opcode, task_key, worker_id, max_count) and are
// taken when valid and ready are both high. Results leave on o_res, one or
// more per request, the final one marked by last.
// The front end takes a new request only once the last one is pushed: it accepts,
// runs two multiplier stages of the hash, then pushes into a two-entry queue.
// The engine handles one job at a time. A probe of one entry is a key memory
// read, then a compare; a slot visit is a slot memory read, then a check.
// Start writes all slots, one per cycle. A list delivers each worker it finds
// in a result item of its own.
// Results sit in an output register; while the receiver stalls the engine
// holds, and the front end and queue keep taking up to three more requests.
// Synchronous reset clears all entries to unused and empties the queue.
`default_nettype none
module task_worker_hash_table_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    twh_req_if.sink   i_req,
    twh_res_if.source o_res
);
    twh_pkg::t_job    w_f_job;
    logic             w_f_valid;
    logic             w_f_ready;
    twh_pkg::t_job    w_q_job;
    logic             w_q_valid;
    logic             w_q_ready;
    twh_pkg::t_q_stat w_q_stat;

    twh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job       (w_f_job),
        .o_job_valid (w_f_valid),
        .i_job_ready (w_f_ready)
    );

    twh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_job   (w_f_job),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .o_pop_job    (w_q_job),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_stat       (w_q_stat)
    );

    twh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_q_job),
        .i_job_valid (w_q_valid),
        .o_job_ready (w_q_ready),
        .o_res       (o_res)
    );

    a_worker_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.has_worker |-> o_res.status == twh_pkg::ST_OK)
        else $error("listed worker with failing status");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.has_worker |-> o_res.last && o_res.worker_out == 8'd0)
        else $error("result without worker is not a final zero result");

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.count <= twh_pkg::QC_W'(twh_pkg::Q_DEPTH)
        && (w_q_stat.full == (w_q_stat.count == twh_pkg::QC_W'(twh_pkg::Q_DEPTH))))
        else $error("queue count out of range");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid |-> w_q_stat.count != '0)
        else $error("queue pops while empty");
endmodule
`default_nettype wire

// ===== rtl/twh_front.sv =====
// Front end: accepts requests and computes the home index with the mixing hash.
`default_nettype none
module twh_front (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    twh_req_if.sink    i_req,
    output twh_pkg::t_job o_job,
    output logic       o_job_valid,
    input  wire logic  i_job_ready
);
    typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_PUSH} t_fstate;

    t_fstate       r_state;
    twh_pkg::t_job r_job;
    logic [31:0]   r_v;
    logic [31:0]   w_x13;

    assign w_x13 = r_v ^ (r_v >> 13);
    assign i_req.ready = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);

    always_comb begin
        o_job      = r_job;
        o_job.home = r_v[twh_pkg::IDX_W-1:0] ^ r_v[16 +: twh_pkg::IDX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_req.valid) begin
                        r_job.opcode    <= i_req.opcode;
                        r_job.task_key  <= i_req.task_key;
                        r_job.worker_id <= i_req.worker_id;
                        r_job.max_count <= i_req.max_count;
                        r_job.home      <= '0;
                        r_v             <= i_req.task_key ^ (i_req.task_key >> 16);
                        r_state         <= F_MUL1;
                    end
                end
                F_MUL1: begin
                    r_v     <= 32'(r_v * twh_pkg::MIX_C1);
                    r_state <= F_MUL2;
                end
                F_MUL2: begin
                    r_v     <= 32'(w_x13 * twh_pkg::MIX_C2);
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/twh_queue.sv =====
// Short job queue between the front end and the table engine.
`default_nettype none
module twh_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire twh_pkg::t_job  i_push_job,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    output twh_pkg::t_job       o_pop_job,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output twh_pkg::t_q_stat    o_stat
);
    twh_pkg::t_job               r_mem [twh_pkg::Q_DEPTH];
    logic [twh_pkg::QP_W-1:0]    r_wp;
    logic [twh_pkg::QP_W-1:0]    r_rp;
    logic [twh_pkg::QC_W-1:0]    r_cnt;
    logic                        w_push;
    logic                        w_pop;

    assign o_push_ready = (r_cnt != twh_pkg::QC_W'(twh_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_stat.count = r_cnt;
    assign o_stat.full  = !o_push_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == twh_pkg::QP_W'(twh_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == twh_pkg::QP_W'(twh_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/twh_back.sv =====
// Table engine: probes entries, walks worker slots and drives the result register.
`default_nettype none
module twh_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire twh_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    twh_res_if.source          o_res
);
    typedef enum logic [3:0] {
        B_IDLE, B_PRD, B_PCMP, B_INIT, B_SRD, B_SCHK,
        B_NRD, B_NCHK, B_DRD, B_DCHK, B_EMIT, B_LEMIT
    } t_bstate;

    localparam int IDX_W  = twh_pkg::IDX_W;
    localparam int SLOT_W = twh_pkg::SLOT_W;
    localparam int ADDR_W = twh_pkg::ADDR_W;
    localparam int N_W    = twh_pkg::N_W;
    localparam int K_W    = twh_pkg::K_W;

    t_bstate                r_state;
    logic [2:0]             r_op;
    logic [31:0]            r_key;
    logic [7:0]             r_wid;
    logic [N_W-1:0]         r_lim;
    logic [IDX_W-1:0]       r_idx;
    logic [twh_pkg::PRB_W-1:0] r_p;
    logic [SLOT_W-1:0]      r_s;
    logic [SLOT_W-1:0]      r_d;
    logic [7:0]             r_fw;
    logic [N_W-1:0]         r_n;
    logic [K_W-1:0]         r_k;
    logic [1:0]             r_st;
    logic [7:0]             r_buf [twh_pkg::LIST_MAX];
    logic [twh_pkg::TABLE_DEPTH-1:0] r_used;

    logic [31:0]            r_key_mem [twh_pkg::TABLE_DEPTH];
    logic [9:0]             r_slot_mem [twh_pkg::TABLE_DEPTH * twh_pkg::SLOTS];
    logic [31:0]            r_key_rd;
    logic [9:0]             r_slot_rd;

    logic                   r_out_valid;
    logic [1:0]             r_out_status;
    logic                   r_out_has;
    logic [7:0]             r_out_worker;
    logic                   r_out_last;

    logic                   w_key_we;
    logic                   w_slot_we;
    logic [ADDR_W-1:0]      w_slot_waddr;
    logic [9:0]             w_slot_wdata;
    logic [ADDR_W-1:0]      w_slot_raddr;
    logic [1:0]             w_tag;
    logic [7:0]             w_wrk;
    logic                   w_out_free;
    logic                   w_s_top;
    logic                   w_hit;
    logic [N_W-1:0]         w_lim;

    assign w_tag      = r_slot_rd[9:8];
    assign w_wrk      = r_slot_rd[7:0];
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_s_top    = (r_s == SLOT_W'(twh_pkg::SLOTS - 1));
    assign w_hit      = r_used[r_idx] && (r_key_rd == r_key);
    assign w_lim      = (i_job.max_count < 4'(twh_pkg::LIST_MAX))
                        ? N_W'(i_job.max_count) : N_W'(twh_pkg::LIST_MAX);
    assign o_job_ready = (r_state == B_IDLE);

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.has_worker = r_out_has;
    assign o_res.worker_out = r_out_worker;
    assign o_res.last       = r_out_last;

    always_comb begin
        w_key_we     = (r_state == B_PCMP) && (r_op == twh_pkg::OP_START) && !r_used[r_idx];
        w_slot_we    = 1'b0;
        w_slot_waddr = {r_idx, r_s};
        w_slot_wdata = {twh_pkg::TAG_UNTOUCHED, 8'd0};
        w_slot_raddr = (r_state == B_DRD) ? {r_idx, r_d} : {r_idx, r_s};
        case (r_state)
            B_INIT: begin
                w_slot_we = 1'b1;
                if (r_s == '0) begin
                    w_slot_wdata = {twh_pkg::TAG_OCCUPIED, r_wid};
                end
            end
            B_SCHK: begin
                if (r_op == twh_pkg::OP_ADD && w_tag != twh_pkg::TAG_OCCUPIED) begin
                    w_slot_we    = 1'b1;
                    w_slot_wdata = {twh_pkg::TAG_OCCUPIED, r_wid};
                end else if (r_op == twh_pkg::OP_REMOVE && w_tag == twh_pkg::TAG_OCCUPIED
                             && w_wrk == r_wid && w_s_top) begin
                    w_slot_we    = 1'b1;
                    w_slot_wdata = {twh_pkg::TAG_UNTOUCHED, w_wrk};
                end
            end
            B_NCHK: begin
                w_slot_we    = 1'b1;
                w_slot_waddr = {r_idx, r_d};
                w_slot_wdata = (w_tag != twh_pkg::TAG_UNTOUCHED)
                               ? {twh_pkg::TAG_EMPTY, r_fw} : {twh_pkg::TAG_UNTOUCHED, r_fw};
            end
            B_DCHK: begin
                w_slot_waddr = {r_idx, r_d};
                w_slot_wdata = {twh_pkg::TAG_UNTOUCHED, w_wrk};
                w_slot_we    = (w_tag == twh_pkg::TAG_EMPTY);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[r_idx] <= r_key;
        end
        r_key_rd <= r_key_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_waddr] <= w_slot_wdata;
        end
        r_slot_rd <= r_slot_mem[w_slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_op  <= i_job.opcode;
                        r_key <= i_job.task_key;
                        r_wid <= i_job.worker_id;
                        r_lim <= w_lim;
                        r_idx <= i_job.home;
                        r_p   <= '0;
                        r_s   <= '0;
                        r_n   <= '0;
                        r_st  <= twh_pkg::ST_OK;
                        r_state <= (i_job.opcode > twh_pkg::OP_LIST) ? B_EMIT : B_PRD;
                    end
                end
                B_PRD: r_state <= B_PCMP;
                B_PCMP: begin
                    if (r_op == twh_pkg::OP_START && !r_used[r_idx]) begin
                        r_used[r_idx] <= 1'b1;
                        r_state       <= B_INIT;
                    end else if (r_op != twh_pkg::OP_START && w_hit) begin
                        if (r_op == twh_pkg::OP_END) begin
                            r_used[r_idx] <= 1'b0;
                            r_state       <= B_EMIT;
                        end else if (r_op == twh_pkg::OP_LIST && r_lim == '0) begin
                            r_state <= B_EMIT;
                        end else begin
                            r_state <= B_SRD;
                        end
                    end else if (r_p == twh_pkg::PRB_W'(twh_pkg::MAX_PROBES - 1)) begin
                        r_st    <= (r_op == twh_pkg::OP_START)
                                   ? twh_pkg::ST_FULL : twh_pkg::ST_NOT_FOUND;
                        r_state <= B_EMIT;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= B_PRD;
                    end
                end
                B_INIT: begin
                    if (w_s_top) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                B_SRD: r_state <= B_SCHK;
                B_SCHK: begin
                    case (r_op)
                        twh_pkg::OP_ADD: begin
                            if (w_tag != twh_pkg::TAG_OCCUPIED) begin
                                r_state <= B_EMIT;
                            end else if (w_s_top) begin
                                r_st    <= twh_pkg::ST_ABSENT;
                                r_state <= B_EMIT;
                            end else begin
                                r_s     <= r_s + 1'b1;
                                r_state <= B_SRD;
                            end
                        end
                        twh_pkg::OP_REMOVE: begin
                            if (w_tag == twh_pkg::TAG_OCCUPIED && w_wrk == r_wid) begin
                                if (w_s_top) begin
                                    r_state <= B_EMIT;
                                end else begin
                                    r_d     <= r_s;
                                    r_fw    <= w_wrk;
                                    r_s     <= r_s + 1'b1;
                                    r_state <= B_NRD;
                                end
                            end else if (w_s_top) begin
                                r_st    <= twh_pkg::ST_ABSENT;
                                r_state <= B_EMIT;
                            end else begin
                                r_s     <= r_s + 1'b1;
                                r_state <= B_SRD;
                            end
                        end
                        default: begin
                            if (w_tag == twh_pkg::TAG_UNTOUCHED) begin
                                r_k     <= '0;
                                r_state <= (r_n == '0) ? B_EMIT : B_LEMIT;
                            end else begin
                                if (w_tag == twh_pkg::TAG_OCCUPIED) begin
                                    r_buf[r_n[K_W-1:0]] <= w_wrk;
                                    r_n <= r_n + 1'b1;
                                end
                                if (w_s_top || (w_tag == twh_pkg::TAG_OCCUPIED
                                                && r_n + 1'b1 == r_lim)) begin
                                    r_k <= '0;
                                    r_state <= (r_n == '0 && w_tag != twh_pkg::TAG_OCCUPIED)
                                               ? B_EMIT : B_LEMIT;
                                end else begin
                                    r_s     <= r_s + 1'b1;
                                    r_state <= B_SRD;
                                end
                            end
                        end
                    endcase
                end
                B_NRD: r_state <= B_NCHK;
                B_NCHK: begin
                    if (w_tag != twh_pkg::TAG_UNTOUCHED || r_d == '0) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_d     <= r_d - 1'b1;
                        r_state <= B_DRD;
                    end
                end
                B_DRD: r_state <= B_DCHK;
                B_DCHK: begin
                    if (w_tag == twh_pkg::TAG_EMPTY && r_d != '0) begin
                        r_d     <= r_d - 1'b1;
                        r_state <= B_DRD;
                    end else begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_st;
                        r_out_has    <= 1'b0;
                        r_out_worker <= 8'd0;
                        r_out_last   <= 1'b1;
                        r_state      <= B_IDLE;
                    end
                end
                B_LEMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= twh_pkg::ST_OK;
                        r_out_has    <= 1'b1;
                        r_out_worker <= r_buf[r_k];
                        r_out_last   <= (N_W'(r_k) + 1'b1 == r_n);
                        r_k          <= r_k + 1'b1;
                        if (N_W'(r_k) + 1'b1 == r_n) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
